// ===== hdl/hpf_pkg.sv =====
// Shared constants, pulse table and controller/datapath interface types.
`default_nettype none

package hpf_pkg;

   // Pulse table geometry: rows by inlet temperature, columns by flow count
   localparam int TEMP_POINTS = 14;
   localparam int FLOW_POINTS = 5;
   localparam int TEMP_BASE   = 16;
   localparam int TEMP_STEP   = 2;
   localparam int FLOW_BASE   = 23;
   localparam int FLOW_STEP   = 5;
   localparam int ROW_W       = $clog2(TEMP_POINTS);
   localparam int COL_W       = $clog2(FLOW_POINTS);
   localparam int TEMP_TOP    = TEMP_BASE + TEMP_STEP * (TEMP_POINTS - 1);

   localparam logic [8:0] PULSE_TABLE [TEMP_POINTS][FLOW_POINTS] = '{
      '{205, 270, 290, 330, 350},
      '{200, 246, 275, 325, 360},
      '{195, 236, 263, 315, 350},
      '{175, 230, 260, 290, 320},
      '{160, 210, 240, 270, 310},
      '{150, 190, 230, 270, 310},
      '{140, 175, 210, 240, 280},
      '{130, 160, 190, 210, 250},
      '{115, 145, 180, 205, 240},
      '{110, 135, 170, 190, 220},
      '{100, 120, 150, 170, 190},
      '{ 85, 110, 130, 150, 170},
      '{ 65,  95, 115, 125, 140},
      '{ 50,  75,  95, 115, 135}
   };

   // Configuration register indexes and reset values
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_TEMP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_CAP      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_MARGIN   = 2'd2;
   localparam logic [7:0] REFERENCE_RESET = 8'd55;
   localparam logic [7:0] PULSE_CAP_RESET = 8'd200;
   localparam logic [7:0] MARGIN_RESET    = 8'd12;

   // Outlet trim factors, in tenths
   localparam logic [3:0] TRIM_CUT  = 4'd9;
   localparam logic [3:0] TRIM_NONE = 4'd10;
   localparam logic [3:0] TRIM_LOW  = 4'd11;
   localparam logic [3:0] TRIM_MID  = 4'd12;
   localparam logic [3:0] TRIM_HIGH = 4'd14;
   localparam logic [7:0] TRIM_MID_GAP  = 8'd1;
   localparam logic [7:0] TRIM_HIGH_GAP = 8'd6;

   // x/10 == (x * RECIP10) >> RECIP10_SHIFT, exact for x below 80000
   localparam logic [15:0] RECIP10       = 16'd52429;
   localparam int          RECIP10_SHIFT = 19;
   // t/10 == (t * SPLIT10) >> SPLIT10_SHIFT, exact for 8-bit t
   localparam logic [7:0]  SPLIT10       = 8'd205;
   localparam int          SPLIT10_SHIFT = 11;

   localparam int DIV_W     = 27;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int FRAC_W    = 14;  // scaled demand saturates at 2^14 - 1

   localparam logic [4:0] WHOLE_MAX = 5'd20;

   typedef struct packed {
      logic load;
      logic interp;
      logic f4;
      logic prod;
      logic div_start;
      logic round;
      logic trim;
      logic scale;
      logic out_load;
   } hpf_cmd_type;

   typedef struct packed {
      logic div_done;
   } hpf_status_type;

endpackage

`default_nettype wire

// ===== hdl/hpf_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module hpf_div import hpf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [7:0]       divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             done
);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [7:0]           rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [8:0]           trial;
   logic [8:0]           diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = DIV_CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         rem_in  = fits ? diff[7:0] : trial[7:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== hdl/hpf_dp.sv =====
// Datapath: config registers, boost flag, table interpolation, scaling, trim, split.
`default_nettype none

module hpf_dp import hpf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  hpf_cmd_type          cmd,
   output hpf_status_type       status,
   input  logic [7:0]           req_flow_count,
   input  logic [7:0]           req_inlet_temp,
   input  logic [7:0]           req_outlet_temp,
   input  logic [7:0]           req_set_temp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   output logic [7:0]           rsp_active_total,
   output logic [4:0]           rsp_whole_pulses,
   output logic [3:0]           rsp_extra_pulses,
   output logic                 rsp_boost_on
);

   // Config and boost state
   logic [7:0] reference_ff, cap_ff, margin_ff;
   logic       boost_ff, boost_in;

   // Item registers
   logic [7:0] flow_ff, tin_ff, tset_ff;
   logic [3:0] trim_ff, trim_in;

   // Pipeline of the work
   logic [9:0]       f1_ff, f2_ff, f1_in, f2_in;
   logic [7:0]       off_ff, off_in;
   logic [19:0]      f4t_ff, f4t_in;
   logic [DIV_W-1:0] dividend_ff, dividend_in;
   logic [7:0]       divisor_ff;
   logic             base_ok_ff, base_ok_in;
   logic [10:0]      total_ff, total_in;
   logic [14:0]      trimmed_ff;
   logic [7:0]       capped_ff, capped_in;

   logic [7:0] total_out_ff;
   logic [4:0] whole_out_ff, whole_in;
   logic [3:0] extra_out_ff, extra_in;
   logic       boost_out_ff;

   // ---------------- load: boost hysteresis and trim selection
   logic [8:0] out_x, set_x;
   logic       enter;

   assign out_x = {1'b0, req_outlet_temp};
   assign set_x = {1'b0, req_set_temp};
   assign enter = (out_x + {1'b0, margin_ff}) < set_x;

   always_comb begin
      boost_in = boost_ff | enter;
      trim_in  = TRIM_NONE;
      if (out_x > set_x) begin
         trim_in = TRIM_CUT;
      end else if (out_x < set_x) begin
         if ((out_x + {1'b0, TRIM_HIGH_GAP}) < set_x) begin
            trim_in = boost_in ? TRIM_HIGH : TRIM_NONE;
         end else if ((out_x + {1'b0, TRIM_MID_GAP}) < set_x) begin
            trim_in = boost_in ? TRIM_MID : TRIM_NONE;
         end else begin
            boost_in = 1'b0;
            trim_in  = TRIM_LOW;
         end
      end
   end

   // ---------------- interp: cell select and row interpolation
   logic [ROW_W-1:0] row, row_nx;
   logic             row_d;
   logic [7:0]       row_off;
   logic [COL_W-1:0] col_lo, col_hi;
   logic [7:0]       col_base;
   logic [8:0]       a_lo, b_lo, a_hi, b_hi;

   assign row_off = tin_ff - 8'(TEMP_BASE);

   always_comb begin
      if (tin_ff < 8'(TEMP_BASE)) begin
         row   = '0;
         row_d = 1'b0;
      end else if (tin_ff >= 8'(TEMP_TOP)) begin
         row   = ROW_W'(TEMP_POINTS - 1);
         row_d = 1'b0;
      end else begin
         row   = row_off[ROW_W:1];
         row_d = row_off[0];
      end
      row_nx = row_d ? row + 1'b1 : row;
   end

   always_comb begin
      col_lo   = '0;
      col_base = 8'(FLOW_BASE);
      for (int k = 1; k < FLOW_POINTS - 1; k++) begin
         if (flow_ff >= 8'(FLOW_BASE + FLOW_STEP * k)) begin
            col_lo   = COL_W'(k);
            col_base = 8'(FLOW_BASE + FLOW_STEP * k);
         end
      end
      if (flow_ff < 8'(FLOW_BASE)) begin
         col_hi = '0;
         off_in = '0;
      end else begin
         col_hi = col_lo + 1'b1;
         off_in = flow_ff - col_base;
      end
   end

   assign a_lo  = PULSE_TABLE[row][col_lo];
   assign b_lo  = PULSE_TABLE[row_nx][col_lo];
   assign a_hi  = PULSE_TABLE[row][col_hi];
   assign b_hi  = PULSE_TABLE[row_nx][col_hi];
   // 2a - d*(a-b) with d in {0,1}
   assign f1_in = {1'b0, a_lo} + {1'b0, row_d ? b_lo : a_lo};
   assign f2_in = {1'b0, a_hi} + {1'b0, row_d ? b_hi : a_hi};

   // ---------------- f4: flow interpolation, value in tenths
   logic signed [10:0] f_diff;
   logic signed [19:0] f_slope;
   logic        [12:0] five_f1;

   assign f_diff  = $signed({1'b0, f1_ff}) - $signed({1'b0, f2_ff});
   assign f_slope = 20'(f_diff * $signed({1'b0, off_ff}));
   assign five_f1 = 13'({f1_ff, 2'b00}) + 13'(f1_ff);
   assign f4t_in  = 20'($signed({7'b0, five_f1}) - f_slope);

   // ---------------- prod: numerator and denominator of the set-point scaling
   logic [7:0] rise;

   assign rise        = tset_ff - tin_ff;
   assign base_ok_in  = (tset_ff > tin_ff) && (tin_ff < reference_ff) &&
                        ($signed(f4t_ff) > 20'sd0);
   assign dividend_in = base_ok_in ? DIV_W'(rise * f4t_ff[18:0]) : '0;

   // ---------------- divider
   logic [DIV_W-1:0] quotient;
   logic             div_done;

   hpf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend_ff),
      .divisor  (divisor_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.div_done = div_done;

   // ---------------- round: (f + 5) / 10
   logic [FRAC_W-1:0] f_sat;
   logic [14:0]       f_rnd;
   logic [30:0]       rnd_prod;

   always_comb begin
      if (!base_ok_ff) begin
         f_sat = '0;
      end else if (quotient[DIV_W-1:FRAC_W] != '0) begin
         f_sat = '1;
      end else begin
         f_sat = quotient[FRAC_W-1:0];
      end
   end

   assign f_rnd    = {1'b0, f_sat} + 15'd5;
   assign rnd_prod = f_rnd * RECIP10;
   assign total_in = rnd_prod[RECIP10_SHIFT+10:RECIP10_SHIFT];

   // ---------------- scale: trim / 10 and cap, zero when the set temperature is 0
   logic [30:0] sc_prod;
   logic [11:0] scaled;

   assign sc_prod = trimmed_ff * RECIP10;
   assign scaled  = sc_prod[RECIP10_SHIFT+11:RECIP10_SHIFT];

   always_comb begin
      if (tset_ff == '0) begin
         capped_in = '0;
      end else if (scaled > {4'b0, cap_ff}) begin
         capped_in = cap_ff;
      end else begin
         capped_in = scaled[7:0];
      end
   end

   // ---------------- split into whole pulses and remainder
   logic [15:0] sp_prod;
   logic [4:0]  whole_raw;
   logic [7:0]  whole_x10;
   logic [7:0]  rem;

   assign sp_prod   = capped_ff * SPLIT10;
   assign whole_raw = sp_prod[SPLIT10_SHIFT+4:SPLIT10_SHIFT];
   assign whole_x10 = {whole_raw, 3'b000} + {2'b00, whole_raw, 1'b0};
   assign rem       = capped_ff - whole_x10;

   always_comb begin
      if (whole_raw > WHOLE_MAX) begin
         whole_in = WHOLE_MAX;
         extra_in = '0;
      end else begin
         whole_in = whole_raw;
         extra_in = rem[3:0];
      end
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reference_ff <= REFERENCE_RESET;
         cap_ff       <= PULSE_CAP_RESET;
         margin_ff    <= MARGIN_RESET;
         boost_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REFERENCE_TEMP: reference_ff <= csr_wdata;
               CSR_PULSE_CAP:      cap_ff       <= csr_wdata;
               CSR_BOOST_MARGIN:   margin_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) begin
            boost_ff <= boost_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         flow_ff <= req_flow_count;
         tin_ff  <= req_inlet_temp;
         tset_ff <= req_set_temp;
         trim_ff <= trim_in;
      end
      if (cmd.interp) begin
         f1_ff  <= f1_in;
         f2_ff  <= f2_in;
         off_ff <= off_in;
      end
      if (cmd.f4) begin
         f4t_ff <= f4t_in;
      end
      if (cmd.prod) begin
         dividend_ff <= dividend_in;
         divisor_ff  <= reference_ff - tin_ff;
         base_ok_ff  <= base_ok_in;
      end
      if (cmd.round) begin
         total_ff <= total_in;
      end
      if (cmd.trim) begin
         trimmed_ff <= 15'(total_ff * trim_ff);
      end
      if (cmd.scale) begin
         capped_ff <= capped_in;
      end
      if (cmd.out_load) begin
         total_out_ff <= capped_ff;
         whole_out_ff <= whole_in;
         extra_out_ff <= extra_in;
         boost_out_ff <= boost_ff;
      end
   end

   assign rsp_active_total = total_out_ff;
   assign rsp_whole_pulses = whole_out_ff;
   assign rsp_extra_pulses = extra_out_ff;
   assign rsp_boost_on     = boost_out_ff;

endmodule

`default_nettype wire

// ===== hdl/hpf_ctrl.sv =====
// Controller: sequences one word through the datapath and owns both handshakes.
`default_nettype none

module hpf_ctrl import hpf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output hpf_cmd_type    cmd,
   input  hpf_status_type status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INTERP,
      S_F4,
      S_PROD,
      S_DIVGO,
      S_DIVWAIT,
      S_ROUND,
      S_TRIM,
      S_SCALE,
      S_SPLIT
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_INTERP;
            end
         end
         S_INTERP: begin
            cmd.interp = 1'b1;
            state_in   = S_F4;
         end
         S_F4: begin
            cmd.f4   = 1'b1;
            state_in = S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (status.div_done) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            state_in  = S_TRIM;
         end
         S_TRIM: begin
            cmd.trim = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_SPLIT;
         end
         S_SPLIT: begin
            // wait until the previous result has left the output register
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_valid_in = cmd.out_load | (out_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/heater_pulse_from_flow_temp_unit.sv =====
// Top level: heater pulse demand from flow and temperatures.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  flow_count, inlet/outlet/set temp
//   rsp      out        rsp_valid/rsp_stall  active_total, whole/extra pulses, boost_on
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One word at a time: a new word is taken only after the last one has been loaded
// into the output register, which waits while an earlier result is still stalled.
// Most of the work on a word is the 27-step restoring divider for the set-point scaling.
// Reset (synchronous) loads the register defaults and clears the boost flag.
// A stalled result sits in the output register while the next word is worked on.
`default_nettype none

module heater_pulse_from_flow_temp_unit import hpf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_flow_count,
   input  logic [7:0]           req_inlet_temp,
   input  logic [7:0]           req_outlet_temp,
   input  logic [7:0]           req_set_temp,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_active_total,
   output logic [4:0]           rsp_whole_pulses,
   output logic [3:0]           rsp_extra_pulses,
   output logic                 rsp_boost_on,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   hpf_cmd_type    cmd;
   hpf_status_type status;

   assign csr_ready = 1'b1;

   hpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   hpf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_flow_count   (req_flow_count),
      .req_inlet_temp   (req_inlet_temp),
      .req_outlet_temp  (req_outlet_temp),
      .req_set_temp     (req_set_temp),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_active_total (rsp_active_total),
      .rsp_whole_pulses (rsp_whole_pulses),
      .rsp_extra_pulses (rsp_extra_pulses),
      .rsp_boost_on     (rsp_boost_on)
   );

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while one is in flight");

   a_split_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_whole_pulses <= WHOLE_MAX) && (rsp_extra_pulses <= 4'd9))
      else $error("pulse split out of range");

   // below 210 the split is exact, 20 whole pulses included
   a_split_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_active_total < 8'd210) |->
         rsp_active_total == (8'(rsp_whole_pulses) * 8'd10 + 8'(rsp_extra_pulses)))
      else $error("whole and extra pulses do not add up to the total");

   a_split_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_active_total >= 8'd210) |->
         (rsp_whole_pulses == WHOLE_MAX) && (rsp_extra_pulses == 4'd0))
      else $error("clamped split inconsistent with total");

endmodule

`default_nettype wire

// ===== tb/sv/tb_heater_pulse_from_flow_temp_unit.sv =====
// Self-checking testbench for the heater pulse demand unit: directed table, random words.
`timescale 1ns / 1ps

module tb_heater_pulse_from_flow_temp_unit import hpf_pkg::*; ();

   localparam int IDLE_LIMIT      = 5000;  // cycles without any handshake
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 204;
   localparam int HOLD_AFTER      = 300;   // words sent before the long rsp hold-off
   localparam int HOLD_CYCLES     = 600;
   localparam int DRAIN_CYCLES    = 60;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;

   // Demand table: rows by inlet (16..42 step 2), columns by flow (23..43 step 5)
   localparam int INLET_ROWS = 14;
   localparam int FLOW_COLS  = 5;
   localparam int INLET_BASE = 16;
   localparam int INLET_STEP = 2;
   localparam int FLOW_BASE  = 23;
   localparam int FLOW_STEP  = 5;
   localparam int WHOLE_CLAMP = 20;
   localparam int DEMAND_TABLE [INLET_ROWS][FLOW_COLS] = '{
      '{205, 270, 290, 330, 350},
      '{200, 246, 275, 325, 360},
      '{195, 236, 263, 315, 350},
      '{175, 230, 260, 290, 320},
      '{160, 210, 240, 270, 310},
      '{150, 190, 230, 270, 310},
      '{140, 175, 210, 240, 280},
      '{130, 160, 190, 210, 250},
      '{115, 145, 180, 205, 240},
      '{110, 135, 170, 190, 220},
      '{100, 120, 150, 170, 190},
      '{ 85, 110, 130, 150, 170},
      '{ 65,  95, 115, 125, 140},
      '{ 50,  75,  95, 115, 135}
   };

   typedef struct packed {
      logic [7:0] total;
      logic [4:0] whole;
      logic [3:0] extra;
      logic       boost;
   } heater_demand_type;

   typedef struct packed {
      logic [7:0] flow;
      logic [7:0] inlet;
      logic [7:0] outlet;
      logic [7:0] setp;
      logic       typed;
      logic [7:0] total;
      logic [4:0] whole;
      logic [3:0] extra;
      logic       boost;
   } demand_vector_type;

   // Register defaults apply; typed rows carry their expected demand.
   localparam int DIRECTED_ROWS = 21;
   localparam demand_vector_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   5'd0,  4'd0, 1'b0}, // heater off
      '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   5'd0,  4'd0, 1'b0}, // inlet above ref
      '{8'd30,  8'd40,  8'd40,  8'd40,  1'b1, 8'd0,   5'd0,  4'd0, 1'b0}, // set == inlet
      '{8'd10,  8'd10,  8'd50,  8'd50,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0}, // below first row/col
      '{8'd30,  8'd17,  8'd45,  8'd45,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0}, // odd inlet
      '{8'd43,  8'd42,  8'd45,  8'd45,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0}, // last row and col
      '{8'd255, 8'd20,  8'd50,  8'd50,  1'b1, 8'd200, 5'd20, 4'd0, 1'b0}, // extrapolated, capped
      '{8'd38,  8'd30,  8'd50,  8'd50,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0},
      '{8'd30,  8'd20,  8'd60,  8'd50,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0}, // outlet above set
      '{8'd30,  8'd20,  8'd49,  8'd50,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0}, // set - 1
      '{8'd30,  8'd20,  8'd37,  8'd50,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0}, // boost enters
      '{8'd30,  8'd20,  8'd47,  8'd50,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0}, // boost held, mid
      '{8'd30,  8'd20,  8'd0,   8'd0,   1'b1, 8'd0,   5'd0,  4'd0, 1'b1}, // off keeps boost
      '{8'd30,  8'd20,  8'd49,  8'd50,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0}, // boost cleared
      '{8'd30,  8'd20,  8'd47,  8'd50,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0},
      '{8'd30,  8'd20,  8'd42,  8'd50,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0},
      '{8'd23,  8'd16,  8'd60,  8'd60,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0},
      '{8'd42,  8'd41,  8'd50,  8'd50,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0},
      '{8'd255, 8'd15,  8'd0,   8'd255, 1'b0, 8'd0,   5'd0,  4'd0, 1'b0},
      '{8'd30,  8'd54,  8'd55,  8'd55,  1'b0, 8'd0,   5'd0,  4'd0, 1'b0},
      '{8'd30,  8'd20,  8'd0,   8'd1,   1'b0, 8'd0,   5'd0,  4'd0, 1'b0}  // margin above set
   };

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_HEAVY, RX_TOGGLE} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_flow_count = '0;
   logic [7:0] req_inlet_temp = '0;
   logic [7:0] req_outlet_temp = '0;
   logic [7:0] req_set_temp = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_active_total;
   logic [4:0] rsp_whole_pulses;
   logic [3:0] rsp_extra_pulses;
   logic rsp_boost_on;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   // predictor copy of registers and boost hysteresis
   logic [7:0] cfg_reference = REFERENCE_RESET;
   logic [7:0] cfg_cap       = PULSE_CAP_RESET;
   logic [7:0] cfg_margin    = MARGIN_RESET;
   logic       boost_model   = 1'b0;

   heater_demand_type pending_demand[$];
   heater_demand_type due;
   int errors = 0;
   int words_sent = 0;
   int results_checked = 0;
   int boosted_results = 0;
   int settings_applied = 0;
   int burst_left = 0;
   bit steady = 1'b0;
   int idle_cycles = 0;
   rx_mode_type rx_mode = RX_OPEN;
   int rx_mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   heater_pulse_from_flow_temp_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_flow_count   (req_flow_count),
      .req_inlet_temp   (req_inlet_temp),
      .req_outlet_temp  (req_outlet_temp),
      .req_set_temp     (req_set_temp),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_active_total (rsp_active_total),
      .rsp_whole_pulses (rsp_whole_pulses),
      .rsp_extra_pulses (rsp_extra_pulses),
      .rsp_boost_on     (rsp_boost_on),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Table entry times INLET_STEP, moved toward the next row by the odd degree
   function automatic longint row_point(input int r, input int d, input int c);
      longint a;
      a = DEMAND_TABLE[r][c];
      if (d > 0 && r + 1 < INLET_ROWS)
         return INLET_STEP * a - d * (a - DEMAND_TABLE[r + 1][c]);
      return INLET_STEP * a;
   endfunction

   // Advances the boost flag as the block does
   function automatic heater_demand_type predict_demand(input logic [7:0] flow_in, inlet_in,
                                                        outlet_in, setp_in);
      longint flow, tin, tout, tset, ref_t, k, off, f1, f2, f4t, scaled, total;
      int col_l, col_h, row, d;
      heater_demand_type res;
      flow = flow_in;
      tin = inlet_in;
      tout = outlet_in;
      tset = setp_in;
      ref_t = cfg_reference;
      res = '0;
      if (tset > 0) begin
         total = 0;
         if (flow < FLOW_BASE) begin
            col_l = 0; col_h = 0; off = 0;
         end else begin
            k = (flow - FLOW_BASE) / FLOW_STEP;
            if (k >= FLOW_COLS - 1) begin
               // extrapolate along the last two columns
               col_l = FLOW_COLS - 2; col_h = FLOW_COLS - 1;
               off = flow - (FLOW_BASE + FLOW_STEP * col_l);
            end else begin
               col_l = int'(k); col_h = int'(k) + 1;
               off = (flow - FLOW_BASE) % FLOW_STEP;
            end
         end
         if (tin < INLET_BASE) begin
            row = 0; d = 0;
         end else begin
            k = (tin - INLET_BASE) / INLET_STEP;
            if (k >= INLET_ROWS - 1) begin
               row = INLET_ROWS - 1; d = 0;
            end else begin
               row = int'(k); d = int'((tin - INLET_BASE) % INLET_STEP);
            end
         end
         f1 = row_point(row, d, col_l);
         f2 = row_point(row, d, col_h);
         f4t = FLOW_STEP * f1 - (f1 - f2) * off;   // tenths
         if (tset > tin && tin < ref_t && f4t > 0) begin
            scaled = ((tset - tin) * f4t) / (ref_t - tin);
            total = (scaled + 5) / 10;
         end
         if (tout > tset) begin
            total = total * 9 / 10;
         end else if (tout < tset) begin
            if (tout < tset - longint'(cfg_margin)) boost_model = 1'b1;
            if (tout < tset - 6) begin
               if (boost_model) total = total * 14 / 10;
            end else if (tout < tset - 1) begin
               if (boost_model) total = total * 12 / 10;
            end else begin
               boost_model = 1'b0;
               total = total * 11 / 10;
            end
         end
         if (total > longint'(cfg_cap)) total = cfg_cap;
         res.total = total[7:0];
         if (total / 10 > WHOLE_CLAMP) begin
            res.whole = 5'(WHOLE_CLAMP);
            res.extra = '0;
         end else begin
            res.whole = 5'(total / 10);
            res.extra = 4'(total % 10);
         end
      end
      res.boost = boost_model;
      return res;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Word offered in bursts; returns at the edge where it was taken
   task automatic send_word(input logic [7:0] flow, inlet, outlet, setp,
                            input bit typed, input heater_demand_type typed_demand);
      heater_demand_type predicted;
      int gap;
      if (burst_left == 0) begin
         steady = ($urandom_range(0, 3) == 0);
         gap = steady ? 0 : $urandom_range(1, 45);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_flow_count  <= flow;
      req_inlet_temp  <= inlet;
      req_outlet_temp <= outlet;
      req_set_temp    <= setp;
      do @(posedge clock); while (req_stall);
      predicted = predict_demand(flow, inlet, outlet, setp);
      pending_demand.push_back(typed ? typed_demand : predicted);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_demand.size() != 0) @(posedge clock);
   endtask

   // csr_valid stays up across back-to-back writes; caller drops it
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_REFERENCE_TEMP: cfg_reference = data;
         CSR_PULSE_CAP:      cfg_cap = data;
         CSR_BOOST_MARGIN:   cfg_margin = data;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] reference, cap, margin);
      write_register(CSR_REFERENCE_TEMP, reference);
      write_register(CSR_PULSE_CAP, cap);
      write_register(CSR_BOOST_MARGIN, margin);
      write_register(CSR_SPARE_IDX, 8'($urandom));   // must be ignored
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Mostly plausible readings near the table; some noise and heater-off words
   task automatic make_word(output logic [7:0] flow, inlet, outlet, setp);
      int kind, tin, tset, tout;
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         flow = 8'($urandom); inlet = 8'($urandom);
         outlet = 8'($urandom); setp = 8'($urandom);
      end else if (kind < 20) begin
         flow = 8'($urandom); inlet = 8'($urandom);
         outlet = 8'($urandom); setp = 8'd0;
      end else begin
         tin = $urandom_range(0, 60);
         flow = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 60));
         if ($urandom_range(0, 9) == 0) tset = $urandom_range(0, tin);
         else tset = tin + $urandom_range(0, 70);
         if (tset > 255) tset = 255;
         tout = tset + $urandom_range(0, 40);
         tout = tout - 28;
         if (tout < 0) tout = 0;
         if (tout > 255) tout = 255;
         inlet = 8'(tin); setp = 8'(tset); outlet = 8'(tout);
      end
   endtask

   // Result check and receiver stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_demand.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected word, expected none, got total %0d boost %0d",
                        $time, rsp_active_total, rsp_boost_on);
            end else begin
               due = pending_demand.pop_front();
               check_field("active_total", due.total, rsp_active_total);
               check_field("whole_pulses", due.whole, rsp_whole_pulses);
               check_field("extra_pulses", due.extra, rsp_extra_pulses);
               check_field("boost_on", due.boost, rsp_boost_on);
               results_checked++;
               if (due.boost) boosted_results++;
            end
         end
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(32, 300);
         end
         rx_mode_left--;
         if (!hold_done && words_sent >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (rx_mode)
               RX_OPEN:  rsp_stall <= 1'b0;
               RX_COIN:  rsp_stall <= 1'($urandom_range(0, 1));
               RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:  rsp_stall <= !rsp_stall;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (!reset && idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [7:0] w_flow, w_inlet, w_outlet, w_setp;
      logic [7:0] s_ref, s_cap, s_margin;
      heater_demand_type typed_demand;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         typed_demand = {DIRECTED[i].total, DIRECTED[i].whole,
                         DIRECTED[i].extra, DIRECTED[i].boost};
         send_word(DIRECTED[i].flow, DIRECTED[i].inlet, DIRECTED[i].outlet,
                   DIRECTED[i].setp, DIRECTED[i].typed, typed_demand);
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin s_ref = 8'd55;  s_cap = 8'd200; s_margin = 8'd12;  end
            1: begin s_ref = 8'd0;   s_cap = 8'd255; s_margin = 8'd0;   end
            2: begin s_ref = 8'd255; s_cap = 8'd0;   s_margin = 8'd255; end
            3: begin s_ref = 8'd255; s_cap = 8'd255; s_margin = 8'd0;   end
            4: begin s_ref = 8'd40;  s_cap = 8'd120; s_margin = 8'd6;   end
            5: begin s_ref = 8'd80;  s_cap = 8'd60;  s_margin = 8'd1;   end
            default: begin
               s_ref = 8'($urandom_range(30, 120));
               s_cap = 8'($urandom);
               s_margin = 8'($urandom_range(0, 30));
            end
         endcase
         wait_drained();
         apply_settings(s_ref, s_cap, s_margin);
         repeat (WORDS_PER_PHASE) begin
            make_word(w_flow, w_inlet, w_outlet, w_setp);
            send_word(w_flow, w_inlet, w_outlet, w_setp, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run: %0d words sent, %0d results checked (%0d with boost on).",
               words_sent, results_checked, boosted_results);
      $display("Register settings applied: %0d, including range extremes.", settings_applied);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
